### rtl/core/drbc_pkg.sv
// Package holding the types, codes and constants of the dirty rectangle bounding box collapse.
package drbc_pkg;

  // List size at which the element count saturates, and the count width it needs.
  localparam int unsigned MAX_LIST = 4096;
  localparam int unsigned COUNT_W = $clog2(MAX_LIST + 1);

  // Bounds on coordinates, sizes and the collapsed box.
  localparam logic signed [15:0] SANE_POS = 16'sd16384;
  localparam logic signed [15:0] SANE_NEG = -16'sd16384;
  localparam logic signed [17:0] BOX_MAX = 18'sd16384;
  localparam logic signed [17:0] BOX_MIN = 18'sd1;

  // Threshold register reset value and its effective lower limit.
  localparam logic [12:0] THRESHOLD_RESET = 13'd200;
  localparam logic [12:0] MIN_THRESHOLD = 13'd8;

  // Reset values of the running box.
  localparam logic signed [15:0] MIN_RESET = 16'sh7FFF;
  localparam logic signed [16:0] MAX_RESET = 17'sh10000;

  // Register indexes on the configuration port.
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // Mode codes; any code at or above active behaves as active.
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_OBSERVE = 2'd1;
  localparam logic [1:0] MODE_ACTIVE = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NO_ACTION = 3'd0,
    ST_BAD_ELEMENT = 3'd1,
    ST_BAD_BOX = 3'd2,
    ST_WOULD_COLLAPSE = 3'd3,
    ST_COLLAPSED = 3'd4
  } status_t;

  // One input item: a rectangle of the list.
  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic [7:0] rect_flag;
    logic last;
  } rect_t;

  // One result item, given when a list closes.
  typedef struct packed {
    logic [2:0] status;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0] box_w;
    logic [14:0] box_h;
    logic box_flag;
    logic [12:0] list_size;
    logic [31:0] collapse_total;
    logic [31:0] collapsed_elements_total;
  } result_t;

  // Running summary of the list, passed from the accumulator to the result stage.
  typedef struct packed {
    logic signed [15:0] min_left;
    logic signed [15:0] min_top;
    logic signed [16:0] max_right;
    logic signed [16:0] max_bottom;
    logic flag_any;
    logic bad_seen;
    logic [COUNT_W-1:0] count;
  } list_sum_t;

endpackage

### rtl/core/dirty_rect_bbox_collapse_core.sv
// Top level of the dirty rectangle bounding box collapse: input register, registers, wiring.
// A closing item passes from the input register to the result register, which shows its result.
// Throughput: one rectangle per cycle unless stalled; the input and result registers each hold one item.
// A waiting result stalls a closing item in the input register, and every rectangle behind it.
// Reset (rst, synchronous): clears the list state, totals and valid flags; mode 0, threshold 200.
module dirty_rect_bbox_collapse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              rect_valid,
  output logic              rect_ready,
  input  drbc_pkg::rect_t   rect,
  output logic              result_valid,
  input  logic              result_ready,
  output drbc_pkg::result_t result
);
  import drbc_pkg::*;

  logic [1:0] mode;
  logic [12:0] threshold;
  logic held_valid;
  rect_t held;
  logic go;
  list_sum_t sum;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OFF;
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MODE: mode <= pwdata[1:0];
        REG_THRESHOLD: threshold <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_MODE: prdata = {30'd0, mode};
      REG_THRESHOLD: prdata = {19'd0, threshold};
      default: prdata = '0;
    endcase
  end

  // The held item moves on unless it closes a list while the result register is still full.
  assign go = held_valid && (!held.last || !result_valid || result_ready);
  assign rect_ready = !held_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rect_valid && rect_ready) begin
      held_valid <= 1'b1;
    end else if (go) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rect_valid && rect_ready) begin
      held <= rect;
    end
  end

  // Running list state.
  drbc_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (held),
    .sum  (sum)
  );

  // Outcome, totals and result register.
  drbc_result u_result (
    .clk          (clk),
    .rst          (rst),
    .fire         (go && held.last),
    .sum          (sum),
    .mode         (mode),
    .threshold    (threshold),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### rtl/core/drbc_accum.sv
// List accumulator: running bounding box, flag OR, bad mark and element count.
module drbc_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  drbc_pkg::rect_t    item,
  output drbc_pkg::list_sum_t sum
);
  import drbc_pkg::*;

  list_sum_t state;
  logic bad;
  logic signed [16:0] right;
  logic signed [16:0] bottom;

  // Element check and far edges of the rectangle.
  always_comb begin
    bad = (item.rect_w < 16'sd0) || (item.rect_h < 16'sd0) ||
          (item.rect_w > SANE_POS) || (item.rect_h > SANE_POS) ||
          (item.rect_x < SANE_NEG) || (item.rect_y < SANE_NEG) ||
          (item.rect_x > SANE_POS) || (item.rect_y > SANE_POS);
    right = $signed({item.rect_x[15], item.rect_x}) + $signed({item.rect_w[15], item.rect_w});
    bottom = $signed({item.rect_y[15], item.rect_y}) + $signed({item.rect_h[15], item.rect_h});
  end

  // Summary including the current item.
  always_comb begin
    sum = state;
    if (state.count < COUNT_W'(MAX_LIST)) begin
      sum.count = state.count + COUNT_W'(1);
    end
    if (bad) begin
      sum.bad_seen = 1'b1;
    end else begin
      if (item.rect_x < state.min_left) sum.min_left = item.rect_x;
      if (item.rect_y < state.min_top) sum.min_top = item.rect_y;
      if (right > state.max_right) sum.max_right = right;
      if (bottom > state.max_bottom) sum.max_bottom = bottom;
      if (item.rect_flag != 8'd0) sum.flag_any = 1'b1;
    end
  end

  // The list state returns to its reset value after the last item.
  always_ff @(posedge clk) begin
    if (rst || (go && item.last)) begin
      state.min_left <= MIN_RESET;
      state.min_top <= MIN_RESET;
      state.max_right <= MAX_RESET;
      state.max_bottom <= MAX_RESET;
      state.flag_any <= 1'b0;
      state.bad_seen <= 1'b0;
      state.count <= '0;
    end else if (go) begin
      state <= sum;
    end
  end

endmodule

### rtl/core/drbc_result.sv
// Result stage: decides the outcome of a closed list, keeps the totals and the output register.
module drbc_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  drbc_pkg::list_sum_t sum,
  input  logic [1:0]          mode,
  input  logic [12:0]         threshold,
  input  logic                result_ready,
  output logic                result_valid,
  output drbc_pkg::result_t   result
);
  import drbc_pkg::*;

  logic [31:0] collapses;
  logic [31:0] elements_collapsed;
  logic [31:0] collapses_next;
  logic [31:0] elements_collapsed_next;
  logic [12:0] thr;
  logic [12:0] n;
  logic signed [17:0] cw;
  logic signed [17:0] ch;
  logic [32:0] csum;
  logic [32:0] esum;
  result_t res_next;

  // Box size and saturating totals.
  always_comb begin
    n = 13'(sum.count);
    thr = (threshold < MIN_THRESHOLD) ? MIN_THRESHOLD : threshold;
    cw = $signed({sum.max_right[16], sum.max_right}) -
         $signed({{2{sum.min_left[15]}}, sum.min_left});
    ch = $signed({sum.max_bottom[16], sum.max_bottom}) -
         $signed({{2{sum.min_top[15]}}, sum.min_top});
    csum = {1'b0, collapses} + 33'd1;
    esum = {1'b0, elements_collapsed} + 33'(n);
  end

  // Outcome of the list.
  always_comb begin
    res_next = '0;
    res_next.status = ST_NO_ACTION;
    res_next.list_size = n;
    collapses_next = collapses;
    elements_collapsed_next = elements_collapsed;
    if ((mode != MODE_OFF) && (n > thr)) begin
      if (sum.bad_seen) begin
        res_next.status = ST_BAD_ELEMENT;
      end else if ((cw < BOX_MIN) || (ch < BOX_MIN) || (cw > BOX_MAX) || (ch > BOX_MAX)) begin
        res_next.status = ST_BAD_BOX;
      end else begin
        res_next.status = (mode >= MODE_ACTIVE) ? ST_COLLAPSED : ST_WOULD_COLLAPSE;
        res_next.box_x = sum.min_left;
        res_next.box_y = sum.min_top;
        res_next.box_w = cw[14:0];
        res_next.box_h = ch[14:0];
        res_next.box_flag = sum.flag_any;
        collapses_next = csum[32] ? '1 : csum[31:0];
        elements_collapsed_next = esum[32] ? '1 : esum[31:0];
      end
    end
    res_next.collapse_total = collapses_next;
    res_next.collapsed_elements_total = elements_collapsed_next;
  end

  // Totals and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      collapses <= '0;
      elements_collapsed <= '0;
      result_valid <= 1'b0;
    end else if (fire) begin
      collapses <= collapses_next;
      elements_collapsed <= elements_collapsed_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

endmodule
